// ----- rtl/scf_pkg.sv -----
// shared constants, status codes, frame view type and crc-32c byte update
// for the snapshot frame checker; no dependencies
`timescale 1ns / 1ps

package scf_pkg;

  localparam int unsigned CNT_W        = 33;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_FORMAT = 1'd1;

  localparam logic [31:0] CRC_POLY     = 32'h82F6_3B78;
  localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
  localparam logic [CNT_W-1:0] COUNT_MAX      = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] HEADER_BYTES   = 33'd48;
  localparam logic [CNT_W-1:0] OVERHEAD_BYTES = 33'd52;
  localparam logic [CNT_W-1:0] FOOTER_BYTES   = 33'd4;
  localparam logic [CNT_W-1:0] HCRC_END_POS   = 33'd15;

  localparam logic [31:0] MAX_PAYLOAD_RST     = 32'd1048576;
  localparam logic [15:0] EXPECTED_FORMAT_RST = 16'd1;

  // magic: "DRNFAB" 0x00 0x01
  localparam logic [7:0] MAGIC [8] = '{8'h44, 8'h52, 8'h4E, 8'h46,
                                       8'h41, 8'h42, 8'h00, 8'h01};

  localparam logic [3:0] ST_OK           = 4'd0;
  localparam logic [3:0] ST_TOO_BIG      = 4'd1;
  localparam logic [3:0] ST_SHORT        = 4'd2;
  localparam logic [3:0] ST_MAGIC        = 4'd3;
  localparam logic [3:0] ST_HDR_CRC      = 4'd4;
  localparam logic [3:0] ST_VERSION      = 4'd5;
  localparam logic [3:0] ST_FLAGS        = 4'd6;
  localparam logic [3:0] ST_MARKER       = 4'd7;
  localparam logic [3:0] ST_LEN_BOUND    = 4'd8;
  localparam logic [3:0] ST_LEN_MISMATCH = 4'd9;
  localparam logic [3:0] ST_BODY_CRC     = 4'd10;
  localparam logic [3:0] ST_FRAME_CRC    = 4'd11;

  // frame state after the current byte, as seen by the status checks
  typedef struct packed {
    logic [CNT_W-1:0] total;
    logic             magic_ok;
    logic [31:0]      hdr_crc_snap;
    logic [31:0]      hdr_crc;
    logic [15:0]      format;
    logic [15:0]      flags;
    logic [63:0]      sequence_no;
    logic [63:0]      incarnation;
    logic [63:0]      length;
    logic [31:0]      body_crc_hdr;
    logic [31:0]      marker;
    logic [31:0]      payload_run;
    logic [31:0]      frame_crc;
    logic [31:0]      footer;
  } frame_view_t;

  // reflected crc-32c, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/scf_in_if.sv -----
// byte input channel of the snapshot frame checker
// depends on nothing
`timescale 1ns / 1ps

interface scf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

// ----- rtl/scf_out_if.sv -----
// result channel of the snapshot frame checker
// depends on nothing
`timescale 1ns / 1ps

interface scf_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [63:0] sequence_res;
  logic [63:0] incarnation;
  logic [31:0] pay_len;
  logic [31:0] payload_checksum;
  logic [15:0] fmt_ver;

  modport source (output valid, status, sequence_res, incarnation, pay_len,
                  payload_checksum, fmt_ver, input ready);
  modport sink   (input valid, status, sequence_res, incarnation, pay_len,
                  payload_checksum, fmt_ver, output ready);
endinterface

// ----- rtl/scf_frame_state.sv -----
// per-frame state: byte counter, footer window, running crcs, header fields
// depends on scf_pkg
`timescale 1ns / 1ps

module scf_frame_state (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output scf_pkg::frame_view_t view
);
  import scf_pkg::*;

  frame_view_t st_r, st_nxt, st_clr;
  logic [31:0] crc_f, crc_p;
  logic [CNT_W-1:0] pos;
  logic [5:0]  p6;

  assign pos = st_r.total;
  assign p6  = pos[5:0];

  always_comb begin
    st_clr           = '0;
    st_clr.magic_ok  = 1'b1;
    st_clr.payload_run = ALL_ONES;
    st_clr.frame_crc = ALL_ONES;
  end

  assign crc_f = crc_byte(st_r.frame_crc, st_r.footer[7:0]);
  assign crc_p = crc_byte(st_r.payload_run, st_r.footer[7:0]);

  always_comb begin
    st_nxt = st_r;
    // oldest byte of the footer window enters the crcs
    if (pos >= FOOTER_BYTES) begin
      st_nxt.frame_crc = crc_f;
      if (pos >= OVERHEAD_BYTES) st_nxt.payload_run = crc_p;
      if (pos == HCRC_END_POS) st_nxt.hdr_crc_snap = crc_f ^ ALL_ONES;
    end
    st_nxt.footer = {data_byte, st_r.footer[31:8]};

    if (pos < HEADER_BYTES) begin
      if (p6 < 6'd8) begin
        if (data_byte != MAGIC[p6[2:0]]) st_nxt.magic_ok = 1'b0;
      end else if (p6 < 6'd10) begin
        st_nxt.format[8*p6[0] +: 8] = st_r.format[8*p6[0] +: 8] | data_byte;
      end else if (p6 < 6'd12) begin
        st_nxt.flags[8*p6[0] +: 8] = st_r.flags[8*p6[0] +: 8] | data_byte;
      end else if (p6 < 6'd16) begin
        st_nxt.hdr_crc[8*p6[1:0] +: 8] = st_r.hdr_crc[8*p6[1:0] +: 8] | data_byte;
      end else if (p6 < 6'd24) begin
        st_nxt.sequence_no[8*p6[2:0] +: 8] =
          st_r.sequence_no[8*p6[2:0] +: 8] | data_byte;
      end else if (p6 < 6'd32) begin
        st_nxt.incarnation[8*p6[2:0] +: 8] =
          st_r.incarnation[8*p6[2:0] +: 8] | data_byte;
      end else if (p6 < 6'd40) begin
        st_nxt.length[8*p6[2:0] +: 8] = st_r.length[8*p6[2:0] +: 8] | data_byte;
      end else if (p6 < 6'd44) begin
        st_nxt.body_crc_hdr[8*p6[1:0] +: 8] =
          st_r.body_crc_hdr[8*p6[1:0] +: 8] | data_byte;
      end else begin
        st_nxt.marker[8*p6[1:0] +: 8] = st_r.marker[8*p6[1:0] +: 8] | data_byte;
      end
    end

    // saturating byte count
    st_nxt.total = (pos != COUNT_MAX) ? pos + 1'b1 : pos;
  end

  assign view = st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= st_clr;
    end else if (step) begin
      st_r <= last_byte ? st_clr : st_nxt;
    end
  end

endmodule

// ----- rtl/scf_status.sv -----
// ordered frame checks giving the result status
// depends on scf_pkg
`timescale 1ns / 1ps

module scf_status (
  input  scf_pkg::frame_view_t view,
  input  logic [31:0]          max_payload_bytes,
  input  logic [15:0]          expected_format,
  output logic [3:0]           status
);
  import scf_pkg::*;

  logic [CNT_W:0] frame_limit;
  logic [64:0]    len_total;

  assign frame_limit = {2'b00, max_payload_bytes} + {1'b0, OVERHEAD_BYTES};
  assign len_total   = {1'b0, view.length} + {32'd0, OVERHEAD_BYTES};

  always_comb begin
    if ({1'b0, view.total} > frame_limit)                        status = ST_TOO_BIG;
    else if (view.total < OVERHEAD_BYTES)                        status = ST_SHORT;
    else if (!view.magic_ok)                                     status = ST_MAGIC;
    else if (view.hdr_crc_snap != view.hdr_crc)                  status = ST_HDR_CRC;
    else if (view.format != expected_format)                     status = ST_VERSION;
    else if (view.flags != 16'd0)                                status = ST_FLAGS;
    else if (view.marker != ALL_ONES)                            status = ST_MARKER;
    else if (view.length > {32'd0, max_payload_bytes})           status = ST_LEN_BOUND;
    else if (len_total != {32'd0, view.total})                   status = ST_LEN_MISMATCH;
    else if ((view.payload_run ^ ALL_ONES) != view.body_crc_hdr) status = ST_BODY_CRC;
    else if ((view.frame_crc ^ ALL_ONES) != view.footer)         status = ST_FRAME_CRC;
    else                                                         status = ST_OK;
  end

endmodule

// ----- rtl/snapshot_frame_checker_core.sv -----
// top level of the snapshot frame checker: input register, frame state, status
// checks and result register; depends on scf_pkg, scf_in_if, scf_out_if
// result: once the last byte of a frame leaves the input register, its result is registered
// throughput: one byte per cycle; a last byte waits in the input register only
// while the result register holds a result that is not taken in that cycle
// reset: synchronous rst_n clears frame state and valids, loads 1048576 and 1
`timescale 1ns / 1ps

module snapshot_frame_checker_core (
  input  logic                            clk,
  input  logic                            rst_n,
  scf_in_if.sink                          in_ch,
  scf_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [scf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import scf_pkg::*;

  // configuration registers
  logic [31:0] max_payload_r;
  logic [15:0] expected_format_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r     <= MAX_PAYLOAD_RST;
      expected_format_r <= EXPECTED_FORMAT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_PAYLOAD:     max_payload_r     <= cfg_wdata;
        REG_EXPECTED_FORMAT: expected_format_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // input register stage
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_adv;
  logic       out_valid_r;
  logic       in_take;

  // a plain byte always moves on; a last byte needs room in the result register
  assign s1_adv      = s1_valid_r && (!s1_last_r || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_ch.data_byte;
      s1_last_r <= in_ch.last_byte;
    end
  end

  // frame state and checks on the state after this byte
  frame_view_t view;
  logic [3:0]  status;

  scf_frame_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .view      (view)
  );

  scf_status u_status (
    .view              (view),
    .max_payload_bytes (max_payload_r),
    .expected_format   (expected_format_r),
    .status            (status)
  );

  // result register
  logic        res_load;
  logic [3:0]  status_r;
  logic [63:0] sequence_r;
  logic [63:0] incarnation_r;
  logic [31:0] length_r;
  logic [31:0] pcrc_r;
  logic [15:0] format_r;

  assign res_load = s1_adv && s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status_r      <= status;
      sequence_r    <= view.sequence_no;
      incarnation_r <= view.incarnation;
      // length is only reported for a good frame
      length_r      <= (status == ST_OK) ? view.length[31:0] : 32'd0;
      pcrc_r        <= view.body_crc_hdr;
      format_r      <= view.format;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = status_r;
  assign out_ch.sequence_res     = sequence_r;
  assign out_ch.incarnation      = incarnation_r;
  assign out_ch.pay_len          = length_r;
  assign out_ch.payload_checksum = pcrc_r;
  assign out_ch.fmt_ver          = format_r;

  // a last byte leaving the input register always shows up as a result
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> out_valid_r)
    else $error("last byte did not produce a result");

  // a held input item keeps its byte
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_byte_r) && $stable(s1_last_r))
    else $error("input register lost a stalled item");

  // a failed frame never reports a length
  a_len_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r != ST_OK |-> length_r == 32'd0)
    else $error("payload length reported on a failed frame");

  // a waiting result is not overwritten
  a_res_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(status_r))
    else $error("pending result overwritten");

endmodule

// ----- tb/scf_tb_pkg.sv -----
// crc-32c byte update used to build frames and to predict the checker's verdicts
// depends on scf_pkg for the polynomial
`timescale 1ns / 1ps

package scf_tb_pkg;

  // reflected crc-32c, data taken lsb first
  function automatic logic [31:0] crc32c_step(input logic [31:0] run, input logic [7:0] d);
    logic [31:0] c;
    logic        fb;
    c = run;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ d[k];
      c  = {1'b0, c[31:1]};
      if (fb) c = c ^ scf_pkg::CRC_POLY;
    end
    return c;
  endfunction

endpackage

// ----- tb/scf_frame_verifier.sv -----
// watches the byte, result and register ports of the snapshot frame checker,
// predicts one verdict per frame and compares; depends on scf_pkg, scf_tb_pkg
`timescale 1ns / 1ps

module scf_frame_verifier (
  input  logic                           clk,
  input  logic                           rst_n,
  scf_in_if                              in_mon,
  scf_out_if                             out_mon,
  input  logic                           cfg_we,
  input  logic [scf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned                    fail_count,
  output int unsigned                    verdicts_owed
);
  import scf_pkg::*;
  import scf_tb_pkg::*;

  typedef struct packed {
    logic [3:0]  status;
    logic [63:0] seq;
    logic [63:0] inc;
    logic [31:0] len;
    logic [31:0] pcrc;
    logic [15:0] fmt;
  } verdict_t;

  // "DRNFAB" 0x00 0x01, byte 0 in the low lane
  localparam logic [63:0] MAGIC_WORD = 64'h0100_4241_464E_5244;

  logic [31:0]      lim_payload;
  logic [15:0]      want_format;
  logic [CNT_W-1:0] seen_bytes;
  logic [31:0]      frame_run, body_run, hdr_snap, tail_win;
  logic             magic_good;
  logic [15:0]      fmt_field, flag_field;
  logic [31:0]      hdr_field, crc_field, marker_field;
  logic [63:0]      seq_field, inc_field, len_field;
  verdict_t         verdict_q[$];
  int unsigned      fails = 0;
  int unsigned      owed = 0;

  assign fail_count    = fails;
  assign verdicts_owed = owed;

  task automatic restart_frame();
    seen_bytes   = '0;
    frame_run    = ALL_ONES;
    body_run     = ALL_ONES;
    hdr_snap     = '0;
    tail_win     = '0;
    magic_good   = 1'b1;
    fmt_field    = '0;
    flag_field   = '0;
    hdr_field    = '0;
    crc_field    = '0;
    marker_field = '0;
    seq_field    = '0;
    inc_field    = '0;
    len_field    = '0;
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic lst);
    logic [CNT_W-1:0] pos;
    logic [5:0]       p;
    logic [63:0]      total, bound;
    logic [3:0]       st;
    verdict_t         v;
    pos = seen_bytes;
    // the byte leaving the footer window enters the running crcs
    if (pos >= 4) begin
      frame_run = crc32c_step(frame_run, tail_win[7:0]);
      if (pos >= 52) body_run = crc32c_step(body_run, tail_win[7:0]);
      if (pos == 15) hdr_snap = ~frame_run;
    end
    tail_win = {b, tail_win[31:8]};
    if (pos < 48) begin
      p = pos[5:0];
      if (p < 8) begin
        if (b != MAGIC_WORD[8*p +: 8]) magic_good = 1'b0;
      end
      else if (p < 10) fmt_field[8*(p-8) +: 8]     = b;
      else if (p < 12) flag_field[8*(p-10) +: 8]   = b;
      else if (p < 16) hdr_field[8*(p-12) +: 8]    = b;
      else if (p < 24) seq_field[8*(p-16) +: 8]    = b;
      else if (p < 32) inc_field[8*(p-24) +: 8]    = b;
      else if (p < 40) len_field[8*(p-32) +: 8]    = b;
      else if (p < 44) crc_field[8*(p-40) +: 8]    = b;
      else             marker_field[8*(p-44) +: 8] = b;
    end
    if (~&seen_bytes) seen_bytes = seen_bytes + 1'b1;
    if (lst) begin
      total = 64'(seen_bytes);
      bound = {32'd0, lim_payload};
      if (total > bound + 64'd52)              st = ST_TOO_BIG;
      else if (total < 64'd52)                 st = ST_SHORT;
      else if (!magic_good)                    st = ST_MAGIC;
      else if (hdr_snap != hdr_field)          st = ST_HDR_CRC;
      else if (fmt_field != want_format)       st = ST_VERSION;
      else if (flag_field != 16'd0)            st = ST_FLAGS;
      else if (marker_field != ALL_ONES)       st = ST_MARKER;
      else if (len_field > bound)              st = ST_LEN_BOUND;
      else if (len_field + 64'd52 != total)    st = ST_LEN_MISMATCH;
      else if (~body_run != crc_field)         st = ST_BODY_CRC;
      else if (~frame_run != tail_win)         st = ST_FRAME_CRC;
      else                                     st = ST_OK;
      v.status = st;
      v.seq    = seq_field;
      v.inc    = inc_field;
      v.len    = (st == ST_OK) ? len_field[31:0] : 32'd0;
      v.pcrc   = crc_field;
      v.fmt    = fmt_field;
      verdict_q.insert(verdict_q.size(), v);
      restart_frame();
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      lim_payload = MAX_PAYLOAD_RST;
      want_format = EXPECTED_FORMAT_RST;
      restart_frame();
      verdict_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected result, status 0x%0h", out_mon.status);
          fails++;
        end else begin
          want = verdict_q.pop_front();
          check_field("status", 64'(want.status), 64'(out_mon.status));
          check_field("sequence_res", want.seq, out_mon.sequence_res);
          check_field("incarnation", want.inc, out_mon.incarnation);
          check_field("pay_len", 64'(want.len), 64'(out_mon.pay_len));
          check_field("payload_checksum", 64'(want.pcrc), 64'(out_mon.payload_checksum));
          check_field("fmt_ver", 64'(want.fmt), 64'(out_mon.fmt_ver));
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_MAX_PAYLOAD) lim_payload = cfg_wdata;
        else if (cfg_index == REG_EXPECTED_FORMAT) want_format = cfg_wdata[15:0];
      end
      if (in_mon.valid && in_mon.ready) absorb_byte(in_mon.data_byte, in_mon.last_byte);
    end
    owed = verdict_q.size();
  end

endmodule

// ----- tb/snapshot_frame_checker_core_tb.sv -----
// stimulus and verdict for the snapshot frame checker: builds good and broken
// frames, drives them through the byte channel; depends on scf_pkg, scf_tb_pkg,
// the channel interfaces, scf_frame_verifier and the block itself
`timescale 1ns / 1ps

module snapshot_frame_checker_core_tb;
  import scf_pkg::*;
  import scf_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_BYTES = 690;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_FRAMES = 1;

  // what the frame builder does to an otherwise well-formed frame
  typedef enum int {
    FK_GOOD, FK_MAGIC, FK_HDR_CRC, FK_VERSION, FK_FLAGS, FK_MARKER, FK_LEN_BOUND,
    FK_LEN_MISMATCH, FK_BODY_CRC, FK_FRAME_CRC, FK_SHORT, FK_TOO_BIG, FK_NOISE
  } frame_kind_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int unsigned           fail_count;
  int unsigned           verdicts_owed;

  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned cycle_count = 0;
  // register values as last written, so that built frames match them
  logic [31:0] cur_max = MAX_PAYLOAD_RST;
  logic [15:0] cur_fmt = EXPECTED_FORMAT_RST;
  logic [7:0]  frame_q[$];

  scf_in_if  in_ch ();
  scf_out_if out_ch ();

  snapshot_frame_checker_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  scf_frame_verifier u_verifier (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .verdicts_owed (verdicts_owed)
  );

  always #4 clk = ~clk;

  // receiver back-pressure and the run's watchdog
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    cycle_count  <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // random mask of width w with at least one bit set
  function automatic logic [31:0] nonzero_bits(input int unsigned w);
    logic [31:0] m;
    m = $urandom;
    m[$urandom_range(w - 1)] = 1'b1;
    return (w >= 32) ? m : (m & ((32'd1 << w) - 1));
  endfunction

  task automatic put_le(input logic [63:0] v, input int unsigned n);
    for (int i = 0; i < n; i++) frame_q.insert(frame_q.size(), v[8*i +: 8]);
  endtask

  // fills frame_q with one frame of the given kind and payload size
  task automatic build_frame(input frame_kind_t kind, input int unsigned plen_in);
    int unsigned plen, cut;
    logic [15:0] fmt_v, flag_v;
    logic [63:0] len_v;
    logic [31:0] marker_v, run, hcrc_v, pcrc_v;
    logic [7:0]  body[$];
    frame_q.delete();
    if (kind == FK_NOISE) begin
      // random bytes, half of them behind a proper magic
      cut = $urandom_range(1, 90);
      if ($urandom_range(1) == 1) begin
        for (int i = 0; i < 8; i++) frame_q.insert(frame_q.size(), MAGIC[i]);
      end
      while (frame_q.size() < cut) frame_q.insert(frame_q.size(), 8'($urandom));
    end else begin
      plen = plen_in;
      // oversize payload only makes sense while the bound is small
      if (kind == FK_TOO_BIG && cur_max < 64) plen = cur_max + 1 + $urandom_range(6);
      else if (plen > cur_max) plen = cur_max;
      fmt_v    = cur_fmt;
      flag_v   = 16'd0;
      len_v    = 64'(plen);
      marker_v = ALL_ONES;
      case (kind)
        FK_VERSION: fmt_v = cur_fmt ^ 16'(nonzero_bits(16));
        FK_FLAGS:   flag_v = 16'(nonzero_bits(16));
        FK_MARKER:  marker_v = ALL_ONES ^ nonzero_bits(32);
        FK_LEN_BOUND: begin
          // just over the bound, or far beyond 32 bits
          if ($urandom_range(1) == 1) len_v = 64'(cur_max) + 64'd1 + 64'($urandom_range(3));
          else len_v = {$urandom | 32'h8000_0000, $urandom};
        end
        FK_LEN_MISMATCH: begin
          if (plen > 0 && $urandom_range(1) == 1) len_v = 64'(plen - 1);
          else len_v = 64'(plen) + 64'($urandom_range(1, 4));
        end
        default: ;
      endcase
      for (int i = 0; i < plen; i++) body.insert(body.size(), 8'($urandom));
      for (int i = 0; i < 8; i++) frame_q.insert(frame_q.size(), MAGIC[i]);
      if (kind == FK_MAGIC) begin
        cut = $urandom_range(7);
        frame_q[cut] = frame_q[cut] ^ 8'(nonzero_bits(8));
      end
      put_le(64'(fmt_v), 2);
      put_le(64'(flag_v), 2);
      // header crc over magic, format and flags
      run = ALL_ONES;
      for (int i = 0; i < 12; i++) run = crc32c_step(run, frame_q[i]);
      hcrc_v = ~run;
      if (kind == FK_HDR_CRC) hcrc_v = hcrc_v ^ nonzero_bits(32);
      put_le(64'(hcrc_v), 4);
      put_le({$urandom, $urandom}, 8);
      put_le({$urandom, $urandom}, 8);
      put_le(len_v, 8);
      run = ALL_ONES;
      foreach (body[i]) run = crc32c_step(run, body[i]);
      pcrc_v = ~run;
      if (kind == FK_BODY_CRC) pcrc_v = pcrc_v ^ nonzero_bits(32);
      put_le(64'(pcrc_v), 4);
      put_le(64'(marker_v), 4);
      foreach (body[i]) frame_q.insert(frame_q.size(), body[i]);
      // footer covers everything before it
      run = ALL_ONES;
      foreach (frame_q[i]) run = crc32c_step(run, frame_q[i]);
      run = ~run;
      if (kind == FK_FRAME_CRC) run = run ^ nonzero_bits(32);
      put_le(64'(run), 4);
      if (kind == FK_SHORT) begin
        cut = $urandom_range(1, 51);
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end
    end
  endtask

  // drives frame_q byte by byte, last mark on the final byte
  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) begin
      while ($urandom_range(99) < send_gap_pct) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
      in_ch.valid     <= 1'b1;
      in_ch.data_byte <= frame_q[i];
      in_ch.last_byte <= (i == frame_q.size() - 1);
      do @(posedge clk); while (!in_ch.ready);
    end
    bytes_sent  += frame_q.size();
    frames_sent++;
  endtask

  // sender holds off until every outstanding verdict has been seen
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (verdicts_owed != 0) @(posedge clk);
  endtask

  // both registers, one after the other, only while the block is idle
  task automatic write_regs(input logic [31:0] max_v, input logic [15:0] fmt_v);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_PAYLOAD;
    cfg_wdata <= max_v;
    @(posedge clk);
    cfg_index <= REG_EXPECTED_FORMAT;
    cfg_wdata <= {16'd0, fmt_v};
    @(posedge clk);
    cfg_we  <= 1'b0;
    cur_max = max_v;
    cur_fmt = fmt_v;
  endtask

  initial begin
    int unsigned byte_mark, frame_mark, pick;
    frame_kind_t kind;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'd0;
    in_ch.last_byte = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed part under the reset register values
    send_gap_pct   = 26;
    recv_stall_pct = 58;
    build_frame(FK_GOOD, 0);
    send_frame();
    // one frame of each kind, too-big needs a small bound and comes later
    for (int k = FK_GOOD; k <= FK_NOISE; k++) begin
      if (k != FK_TOO_BIG) begin
        build_frame(frame_kind_t'(k), $urandom_range(1, 40));
        send_frame();
      end
    end
    // hold off until the pipe is empty
    wait_quiet();
    repeat (4) @(posedge clk);
    write_regs(32'd4, cur_fmt);
    build_frame(FK_TOO_BIG, 0);
    send_frame();
    // payload exactly at the bound
    build_frame(FK_GOOD, 4);
    send_frame();

    // random part: idling pattern changes every two phases, registers every phase
    byte_mark  = bytes_sent;
    frame_mark = frames_sent;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_quiet();
      repeat (4) @(posedge clk);
      case (ph)
        0:       write_regs(32'd0, 16'hFFFF);
        1:       write_regs(32'hFFFF_FFFF, 16'd0);
        2:       write_regs(32'd12, 16'($urandom));
        3:       write_regs(MAX_PAYLOAD_RST, EXPECTED_FORMAT_RST);
        4:       write_regs(32'd60, 16'h8000);
        default: write_regs($urandom_range(40), 16'($urandom));
      endcase
      case (ph / 2)
        0:       begin send_gap_pct = 26; recv_stall_pct = 58; end
        1:       begin send_gap_pct = 58; recv_stall_pct = 26; end
        default: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      endcase
      while (bytes_sent < byte_mark + (ph + 1) * RANDOM_BYTES / PHASES ||
             frames_sent < frame_mark + (ph + 1) * PHASE_FRAMES) begin
        // mostly well-formed frames, a third broken, the rest noise
        pick = $urandom_range(99);
        if (pick < 55)      kind = FK_GOOD;
        else if (pick < 88) kind = frame_kind_t'($urandom_range(FK_MAGIC, FK_TOO_BIG));
        else                kind = FK_NOISE;
        if (kind == FK_TOO_BIG && cur_max >= 64) kind = FK_GOOD;
        build_frame(kind, ($urandom_range(15) == 0) ? $urandom_range(200)
                                                    : $urandom_range(24));
        send_frame();
      end
    end

    // let what is still in flight come out, then allow for the result latency
    wait_quiet();
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
